// ----- rtl/ptsp_pkg.sv -----
// Shared types, constants and small tables for the property tag stream parser.
// Used by the top level and by the port checker; no dependencies.
`default_nettype none

package ptsp_pkg;

	// field widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_W     = 31;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned TYPE_W    = 4;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned SHIFT_W   = 5;

	// result tdata layout, lowest bit first
	localparam int unsigned TD_NAME_LSB   = 0;
	localparam int unsigned TD_TYPE_LSB   = 32;
	localparam int unsigned TD_ARRAY_BIT  = 36;
	localparam int unsigned TD_STRUCT_LSB = 37;
	localparam int unsigned TD_SIZE_LSB   = 69;
	localparam int unsigned TD_ELEM_LSB   = 101;
	localparam int unsigned TD_IPOS_LSB   = 133;
	localparam int unsigned TD_USED_W     = 165;
	localparam int unsigned TD_W          = 168;
	localparam int unsigned TD_PAD_W      = TD_W - TD_USED_W;

	// result tuser layout
	localparam int unsigned TU_CLEAR_BIT = 0;
	localparam int unsigned TU_BAD_BIT   = 1;
	localparam int unsigned TU_W         = 2;

	// compact index framing
	localparam logic [BYTE_W-1:0] IDX_FIRST_MASK = 8'h3f;
	localparam logic [BYTE_W-1:0] IDX_NEXT_MASK  = 8'h7f;
	localparam logic [CNT_W-1:0]  IDX_MAX_EXTRA  = 3'd4;

	// info byte type codes
	localparam logic [TYPE_W-1:0] TYPE_STRUCT = 4'd10;
	localparam logic [TYPE_W-1:0] TYPE_BOOL   = 4'd3;

	// size classes up to this one carry a fixed size
	localparam logic [2:0] LAST_FIXED_CLASS = 3'd4;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NONE_NAME   = 2'd0,
		CFG_TARGET_NAME = 2'd1,
		CFG_NAME_COUNT  = 2'd2
	} cfg_idx_t;

	// parse phases, one-hot
	typedef enum logic [6:0] {
		PH_NAME   = 7'b0000001,
		PH_INFO   = 7'b0000010,
		PH_STRUCT = 7'b0000100,
		PH_SIZE   = 7'b0001000,
		PH_ELEM   = 7'b0010000,
		PH_SKIP   = 7'b0100000,
		PH_DONE   = 7'b1000000
	} phase_t;

	// one decoded header record
	typedef struct packed {
		logic [WORD_W-1:0] info_position;
		logic [WORD_W-1:0] element_index;
		logic [WORD_W-1:0] payload_size;
		logic [WORD_W-1:0] struct_name;
		logic              array_bit;
		logic [TYPE_W-1:0] tag_type;
		logic [WORD_W-1:0] tag_name;
		logic              clear_target;
		logic              list_end;
		logic              bad_name;
	} rec_t;

	// payload size of the fixed size classes
	function automatic logic [WORD_W-1:0] fixed_size(input logic [2:0] cls);
		logic [WORD_W-1:0] s;
		case (cls)
			3'd0:    s = 32'd1;
			3'd1:    s = 32'd2;
			3'd2:    s = 32'd4;
			3'd3:    s = 32'd12;
			3'd4:    s = 32'd16;
			default: s = 32'd0;
		endcase
		return s;
	endfunction

	// number of explicit size bytes for the variable size classes
	function automatic logic [CNT_W-1:0] size_bytes(input logic [2:0] cls);
		logic [CNT_W-1:0] n;
		case (cls)
			3'd5:    n = 3'd1;
			3'd6:    n = 3'd2;
			3'd7:    n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// bit offset of a continuation byte of a compact index
	function automatic logic [SHIFT_W-1:0] idx_shift(input logic [CNT_W-1:0] cnt);
		logic [SHIFT_W-1:0] sh;
		case (cnt)
			3'd1:    sh = 5'd6;
			3'd2:    sh = 5'd13;
			3'd3:    sh = 5'd20;
			3'd4:    sh = 5'd27;
			default: sh = 5'd0;
		endcase
		return sh;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/property_tag_stream_parser_core.sv -----
// Top level of the property tag stream parser: byte input register, header decode,
// record output register. Depends on ptsp_pkg.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  s       | s_tvalid s_tready s_tdata s_tuser        | in
//  m       | m_tvalid m_tready m_tdata m_tuser m_tlast | out
//  cfg     | cfg_we cfg_index cfg_data                | in
//
// One byte is taken every cycle unless a stall on m holds the input; the byte that completes
// a header passes the input register, then the record register, before its record appears.
// The byte register moves on whenever the record register is empty or being taken, so a
// stall on m holds the byte in s1 and drops s_tready in the same cycle (s1 already empty:
// one more byte is taken first and s_tready drops in the cycle after).
// arst_n clears the parser, the position counter and all registers but out_q; no clearing pass.
// A byte with s_tuser set restarts the parser at offset zero before it is decoded.
`default_nettype none

module property_tag_stream_parser_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// byte input
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [ptsp_pkg::BYTE_W-1:0]   s_tdata,  // [7:0] data_byte
	input  wire logic                          s_tuser,  // [0] start_object
	// record output
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [31:0] tag_name, [35:32] tag_type, [36] array_bit, [68:37] struct_name,
	// [100:69] payload_size, [132:101] element_index, [164:133] info_position, rest zero
	output logic [ptsp_pkg::TD_W-1:0]          m_tdata,
	output logic [ptsp_pkg::TU_W-1:0]          m_tuser,  // [0] clear_target, [1] bad_name
	output logic                               m_tlast,  // list_end
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [ptsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ptsp_pkg::CFG_W-1:0]    cfg_data
);

	// configuration registers
	logic [ptsp_pkg::CFG_W-1:0] none_name_q, target_name_q, name_count_q;

	// input stage
	logic                        v_s1;
	logic [ptsp_pkg::BYTE_W-1:0] byte_s1;
	logic                        start_s1;

	// parser state
	ptsp_pkg::phase_t            phase_q;
	logic [ptsp_pkg::WORD_W-1:0] acc_q;
	logic [ptsp_pkg::CNT_W-1:0]  icnt_q;
	logic                        neg_q;
	logic [ptsp_pkg::WORD_W-1:0] name_q;
	logic [ptsp_pkg::BYTE_W-1:0] info_q;
	logic [ptsp_pkg::WORD_W-1:0] sname_q;
	logic [ptsp_pkg::WORD_W-1:0] size_q;
	logic [ptsp_pkg::CNT_W-1:0]  scnt_q;
	logic [ptsp_pkg::WORD_W-1:0] skip_q;
	logic [ptsp_pkg::WORD_W-1:0] pos_q;
	logic [ptsp_pkg::WORD_W-1:0] ipos_q;

	// output register
	logic            out_v_q;
	ptsp_pkg::rec_t  out_q;

	// next state
	ptsp_pkg::phase_t            ph_n;
	logic [ptsp_pkg::WORD_W-1:0] acc_n, name_n, sname_n, size_n, skip_n, pos_n, ipos_n;
	logic [ptsp_pkg::CNT_W-1:0]  icnt_n, scnt_n;
	logic                        neg_n;
	logic [ptsp_pkg::BYTE_W-1:0] info_n;
	ptsp_pkg::rec_t              rec;
	logic                        rec_v;

	// view of state after an object restart
	ptsp_pkg::phase_t            ph_e;
	logic [ptsp_pkg::WORD_W-1:0] acc_e, pos_e;
	logic [ptsp_pkg::CNT_W-1:0]  icnt_e;
	logic                        neg_e;

	// compact index step
	logic [ptsp_pkg::WORD_W-1:0] idx_acc, idx_val;
	logic                        idx_more, idx_neg;
	logic [ptsp_pkg::CNT_W-1:0]  idx_cnt;

	// header sequencing
	logic                        do_start_size, do_after_size, do_finish;
	logic [ptsp_pkg::WORD_W-1:0] fin_elem;
	logic [2:0]                  cls_n;
	logic                        adv;

	// handshake
	assign adv      = !out_v_q || m_tready;
	assign s_tready = !v_s1 || adv;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			none_name_q   <= '0;
			target_name_q <= '0;
			name_count_q  <= '0;
		end else if (cfg_we) begin
			case (ptsp_pkg::cfg_idx_t'(cfg_index))
				ptsp_pkg::CFG_NONE_NAME:   none_name_q   <= cfg_data;
				ptsp_pkg::CFG_TARGET_NAME: target_name_q <= cfg_data;
				ptsp_pkg::CFG_NAME_COUNT:  name_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			byte_s1  <= '0;
			start_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
			if (s_tvalid) begin
				byte_s1  <= s_tdata;
				start_s1 <= s_tuser;
			end
		end
	end

	// restart view
	always_comb begin
		ph_e   = start_s1 ? ptsp_pkg::PH_NAME : phase_q;
		acc_e  = start_s1 ? '0 : acc_q;
		icnt_e = start_s1 ? '0 : icnt_q;
		neg_e  = start_s1 ? 1'b0 : neg_q;
		pos_e  = start_s1 ? '0 : pos_q;
	end

	// one byte of a compact index
	always_comb begin
		if (icnt_e == '0) begin
			idx_acc  = {24'd0, byte_s1 & ptsp_pkg::IDX_FIRST_MASK};
			idx_neg  = byte_s1[7];
			idx_more = byte_s1[6];
		end else begin
			idx_acc  = acc_e | ({24'd0, byte_s1 & ptsp_pkg::IDX_NEXT_MASK}
				<< ptsp_pkg::idx_shift(icnt_e));
			idx_neg  = neg_e;
			idx_more = byte_s1[7] && (icnt_e < ptsp_pkg::IDX_MAX_EXTRA);
		end
		idx_cnt = icnt_e + 3'd1;
		idx_val = idx_neg ? (32'd0 - idx_acc) : idx_acc;
	end

	// header decode for the byte in s1
	always_comb begin
		ph_n    = ph_e;
		acc_n   = acc_e;
		icnt_n  = icnt_e;
		neg_n   = neg_e;
		name_n  = name_q;
		info_n  = info_q;
		sname_n = sname_q;
		size_n  = size_q;
		scnt_n  = scnt_q;
		skip_n  = skip_q;
		ipos_n  = ipos_q;
		pos_n   = pos_e + 32'd1;
		rec     = '0;
		rec_v   = 1'b0;
		do_start_size = 1'b0;
		do_after_size = 1'b0;
		do_finish     = 1'b0;
		fin_elem      = '0;

		// index accumulation in the three index phases
		if (ph_e == ptsp_pkg::PH_NAME || ph_e == ptsp_pkg::PH_STRUCT
				|| ph_e == ptsp_pkg::PH_ELEM) begin
			if (idx_more) begin
				acc_n  = idx_acc;
				icnt_n = idx_cnt;
				neg_n  = idx_neg;
			end else begin
				acc_n  = '0;
				icnt_n = '0;
				neg_n  = 1'b0;
			end
		end

		case (ph_e)
			ptsp_pkg::PH_NAME: begin
				if (!idx_more) begin
					name_n       = idx_val;
					rec.tag_name = idx_val;
					if (idx_val >= {1'b0, name_count_q}) begin
						ph_n         = ptsp_pkg::PH_DONE;
						rec.bad_name = 1'b1;
						rec_v        = 1'b1;
					end else if (idx_val == {1'b0, none_name_q}) begin
						ph_n         = ptsp_pkg::PH_DONE;
						rec.list_end = 1'b1;
						rec_v        = 1'b1;
					end else begin
						ph_n = ptsp_pkg::PH_INFO;
					end
				end
			end
			ptsp_pkg::PH_INFO: begin
				info_n  = byte_s1;
				ipos_n  = pos_e;
				sname_n = '0;
				size_n  = '0;
				scnt_n  = '0;
				if (byte_s1[3:0] == ptsp_pkg::TYPE_STRUCT)
					ph_n = ptsp_pkg::PH_STRUCT;
				else
					do_start_size = 1'b1;
			end
			ptsp_pkg::PH_STRUCT: begin
				if (!idx_more) begin
					sname_n       = idx_val;
					do_start_size = 1'b1;
				end
			end
			ptsp_pkg::PH_SIZE: begin
				size_n = size_q | ({24'd0, byte_s1} << {scnt_q[1:0], 3'b000});
				scnt_n = scnt_q + 3'd1;
				if (scnt_n >= ptsp_pkg::size_bytes(info_q[6:4]))
					do_after_size = 1'b1;
			end
			ptsp_pkg::PH_ELEM: begin
				if (!idx_more) begin
					do_finish = 1'b1;
					fin_elem  = idx_val;
				end
			end
			ptsp_pkg::PH_SKIP: begin
				skip_n = skip_q - 32'd1;
				if (skip_n == '0)
					ph_n = ptsp_pkg::PH_NAME;
			end
			ptsp_pkg::PH_DONE: ;
			default: ;
		endcase

		// size class decode
		cls_n = info_n[6:4];
		if (do_start_size) begin
			if (cls_n <= ptsp_pkg::LAST_FIXED_CLASS) begin
				size_n        = ptsp_pkg::fixed_size(cls_n);
				do_after_size = 1'b1;
			end else begin
				size_n = '0;
				scnt_n = '0;
				ph_n   = ptsp_pkg::PH_SIZE;
			end
		end

		// element index follows for arrays that are not bools
		if (do_after_size) begin
			if (info_n[7] && info_n[3:0] != ptsp_pkg::TYPE_BOOL)
				ph_n = ptsp_pkg::PH_ELEM;
			else
				do_finish = 1'b1;
		end

		// header record and move to payload
		if (do_finish) begin
			rec.tag_name      = name_n;
			rec.tag_type      = info_n[3:0];
			rec.array_bit     = info_n[7];
			rec.struct_name   = sname_n;
			rec.payload_size  = size_n;
			rec.element_index = fin_elem;
			rec.info_position = ipos_n;
			rec.clear_target  = (name_n == {1'b0, target_name_q}) && info_n[7];
			rec_v             = 1'b1;
			skip_n            = size_n;
			ph_n              = (size_n != '0) ? ptsp_pkg::PH_SKIP : ptsp_pkg::PH_NAME;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ptsp_pkg::PH_NAME;
			acc_q   <= '0;
			icnt_q  <= '0;
			neg_q   <= 1'b0;
			name_q  <= '0;
			info_q  <= '0;
			sname_q <= '0;
			size_q  <= '0;
			scnt_q  <= '0;
			skip_q  <= '0;
			pos_q   <= '0;
			ipos_q  <= '0;
		end else if (v_s1 && adv) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			icnt_q  <= icnt_n;
			neg_q   <= neg_n;
			name_q  <= name_n;
			info_q  <= info_n;
			sname_q <= sname_n;
			size_q  <= size_n;
			scnt_q  <= scnt_n;
			skip_q  <= skip_n;
			pos_q   <= pos_n;
			ipos_q  <= ipos_n;
		end
	end

	// record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1 && rec_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && rec_v)
			out_q <= rec;
	end

	// output packing
	assign m_tvalid = out_v_q;
	assign m_tdata  = {{ptsp_pkg::TD_PAD_W{1'b0}}, out_q.info_position, out_q.element_index,
		out_q.payload_size, out_q.struct_name, out_q.array_bit, out_q.tag_type,
		out_q.tag_name};
	assign m_tuser  = {out_q.bad_name, out_q.clear_target};
	assign m_tlast  = out_q.list_end;

endmodule

`default_nettype wire

// ----- rtl/ptsp_checker.sv -----
// Port-level checks for the property tag stream parser and their bind to the top level.
// Depends on ptsp_pkg and property_tag_stream_parser_core.
`default_nettype none

module ptsp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [ptsp_pkg::TD_W-1:0]    m_tdata,
	input wire logic [ptsp_pkg::TU_W-1:0]    m_tuser,
	input wire logic                         m_tlast
);

	// a stalled record holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("record changed while stalled");

	// terminator and bad name never share a record
	a_end_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tlast && m_tuser[ptsp_pkg::TU_BAD_BIT]))
		else $error("list end and bad name together");

	// a list end or bad name record carries only the name
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tlast || m_tuser[ptsp_pkg::TU_BAD_BIT])
			|-> m_tdata[ptsp_pkg::TD_W-1:ptsp_pkg::TD_TYPE_LSB] == '0
			&& !m_tuser[ptsp_pkg::TU_CLEAR_BIT])
		else $error("terminating record has header fields");

	// the clear flag needs the array bit
	a_clear_arr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[ptsp_pkg::TU_CLEAR_BIT] |-> m_tdata[ptsp_pkg::TD_ARRAY_BIT])
		else $error("clear flag without array bit");

endmodule

bind property_tag_stream_parser_core ptsp_checker u_ptsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for property_tag_stream_parser_core: directed byte table, then
// random object streams, with every record checked against a table entry or an in-bench parser.
// Depends on ptsp_pkg and the core top level.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE      = 6;
	localparam int unsigned SEG_BYTES   = 250;
	localparam int unsigned NUM_SEGS    = 6;

	// one byte of stimulus, or one register write in the directed table
	typedef struct {
		logic [7:0]          data;
		bit                  sobj;
		bit                  is_cfg;
		ptsp_pkg::cfg_idx_t  idx;
		logic [30:0]         val;
		bit                  typed;
		ptsp_pkg::rec_t      want;
	} step_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ptsp_pkg::BYTE_W-1:0]    s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [ptsp_pkg::TD_W-1:0]      m_tdata;
	logic [ptsp_pkg::TU_W-1:0]      m_tuser;
	logic                           m_tlast;
	logic                           cfg_we;
	logic [ptsp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ptsp_pkg::CFG_W-1:0]     cfg_data;

	property_tag_stream_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// shadow registers and parser state of the predictor
	logic [30:0]      sh_none, sh_target, sh_count;
	ptsp_pkg::phase_t ph;
	logic [31:0]      acc;
	logic [2:0]       icnt;
	bit               ineg;
	logic [31:0]      hname, hsname, hsize, skip_left, bpos, hipos;
	logic [7:0]       hinfo;
	logic [2:0]       scnt;

	ptsp_pkg::rec_t hdr_q[$];
	step_t          byte_q[$];
	step_t          dir_rows[$];
	step_t          cur_byte;
	bit             s_fire;
	int             errors;
	int             cycles;
	int             tx_idle, rx_idle;

	logic [30:0] seg_none[NUM_SEGS], seg_target[NUM_SEGS], seg_count[NUM_SEGS];

	function automatic ptsp_pkg::rec_t mk_rec(input logic [31:0] name, input logic [3:0] ty,
			input bit arr, input logic [31:0] sname, input logic [31:0] size,
			input logic [31:0] elem, input logic [31:0] ipos, input bit clr,
			input bit lend, input bit bad);
		ptsp_pkg::rec_t r;
		r.tag_name      = name;
		r.tag_type      = ty;
		r.array_bit     = arr;
		r.struct_name   = sname;
		r.payload_size  = size;
		r.element_index = elem;
		r.info_position = ipos;
		r.clear_target  = clr;
		r.list_end      = lend;
		r.bad_name      = bad;
		return r;
	endfunction

	function automatic ptsp_pkg::rec_t stop_rec(input logic [31:0] name, input bit lend,
			input bit bad);
		return mk_rec(name, 4'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, lend, bad);
	endfunction

	function automatic void parser_clear();
		ph        = ptsp_pkg::PH_NAME;
		acc       = '0;
		icnt      = '0;
		ineg      = 1'b0;
		hname     = '0;
		hinfo     = '0;
		hsname    = '0;
		hsize     = '0;
		scnt      = '0;
		skip_left = '0;
		hipos     = '0;
	endfunction

	// one byte of a compact index; 1 when the value is complete
	function automatic bit idx_take(input logic [7:0] b, output logic [31:0] v);
		bit more;
		v = '0;
		if (icnt == 3'd0) begin
			acc  = {26'd0, b[5:0]};
			ineg = b[7];
			more = b[6];
			icnt = 3'd1;
		end else begin
			acc  = acc | ({25'd0, b[6:0]} << (6 + 7 * (int'(icnt) - 1)));
			more = b[7] && (icnt < 3'd4);
			icnt = icnt + 3'd1;
		end
		if (more)
			return 1'b0;
		v    = ineg ? (32'd0 - acc) : acc;
		icnt = '0;
		acc  = '0;
		ineg = 1'b0;
		return 1'b1;
	endfunction

	// header record out, then on to the payload
	function automatic bit finish_header(input logic [31:0] elem, output ptsp_pkg::rec_t r);
		bit clr;
		clr = (hname == {1'b0, sh_target}) && hinfo[7];
		r = mk_rec(hname, hinfo[3:0], hinfo[7], hsname, hsize, elem, hipos, clr, 1'b0, 1'b0);
		skip_left = hsize;
		ph = (hsize != 32'd0) ? ptsp_pkg::PH_SKIP : ptsp_pkg::PH_NAME;
		return 1'b1;
	endfunction

	function automatic bit after_size(output ptsp_pkg::rec_t r);
		r = '0;
		if (hinfo[7] && hinfo[3:0] != ptsp_pkg::TYPE_BOOL) begin
			ph = ptsp_pkg::PH_ELEM;
			return 1'b0;
		end
		return finish_header(32'd0, r);
	endfunction

	function automatic bit start_size(output ptsp_pkg::rec_t r);
		r = '0;
		if (hinfo[6:4] <= ptsp_pkg::LAST_FIXED_CLASS) begin
			case (hinfo[6:4])
				3'd0:    hsize = 32'd1;
				3'd1:    hsize = 32'd2;
				3'd2:    hsize = 32'd4;
				3'd3:    hsize = 32'd12;
				default: hsize = 32'd16;
			endcase
			return after_size(r);
		end
		hsize = '0;
		scnt  = '0;
		ph    = ptsp_pkg::PH_SIZE;
		return 1'b0;
	endfunction

	// predicted effect of one accepted byte
	function automatic bit parse_byte(input logic [7:0] b, input bit sobj,
			output ptsp_pkg::rec_t r);
		logic [31:0] pos;
		logic [31:0] v;
		int          nbytes;
		r = '0;
		if (sobj) begin
			parser_clear();
			bpos = '0;
		end
		pos  = bpos;
		bpos = bpos + 32'd1;
		case (ph)
			ptsp_pkg::PH_NAME: begin
				if (!idx_take(b, v))
					return 1'b0;
				hname = v;
				if (v >= {1'b0, sh_count}) begin
					ph = ptsp_pkg::PH_DONE;
					r  = stop_rec(v, 1'b0, 1'b1);
					return 1'b1;
				end
				if (v == {1'b0, sh_none}) begin
					ph = ptsp_pkg::PH_DONE;
					r  = stop_rec(v, 1'b1, 1'b0);
					return 1'b1;
				end
				ph = ptsp_pkg::PH_INFO;
				return 1'b0;
			end
			ptsp_pkg::PH_INFO: begin
				hinfo  = b;
				hipos  = pos;
				hsname = '0;
				hsize  = '0;
				scnt   = '0;
				if (b[3:0] == ptsp_pkg::TYPE_STRUCT) begin
					ph = ptsp_pkg::PH_STRUCT;
					return 1'b0;
				end
				return start_size(r);
			end
			ptsp_pkg::PH_STRUCT: begin
				if (!idx_take(b, v))
					return 1'b0;
				hsname = v;
				return start_size(r);
			end
			ptsp_pkg::PH_SIZE: begin
				hsize  = hsize | ({24'd0, b} << (8 * int'(scnt[1:0])));
				scnt   = scnt + 3'd1;
				nbytes = (hinfo[6:4] == 3'd5) ? 1 : (hinfo[6:4] == 3'd6) ? 2 : 4;
				if (int'(scnt) < nbytes)
					return 1'b0;
				return after_size(r);
			end
			ptsp_pkg::PH_ELEM: begin
				if (!idx_take(b, v))
					return 1'b0;
				return finish_header(v, r);
			end
			ptsp_pkg::PH_SKIP: begin
				skip_left = skip_left - 32'd1;
				if (skip_left == 32'd0)
					ph = ptsp_pkg::PH_NAME;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic cmp_field(input string fname, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $realtime, fname, e, a);
			errors++;
		end
	endtask

	// record check first, then prediction of the byte taken at this edge
	always @(posedge clk) begin
		ptsp_pkg::rec_t want;
		ptsp_pkg::rec_t nxt;
		bit             made;
		s_fire = s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (hdr_q.size() == 0) begin
					$display("%0t: record with nothing expected, expected none actual %h",
						$realtime, m_tdata);
					errors++;
				end else begin
					want = hdr_q.pop_front();
					cmp_field("tag_name", want.tag_name,
						m_tdata[ptsp_pkg::TD_NAME_LSB +: 32]);
					cmp_field("tag_type", 32'(want.tag_type),
						32'(m_tdata[ptsp_pkg::TD_TYPE_LSB +: 4]));
					cmp_field("array_bit", 32'(want.array_bit),
						32'(m_tdata[ptsp_pkg::TD_ARRAY_BIT]));
					cmp_field("struct_name", want.struct_name,
						m_tdata[ptsp_pkg::TD_STRUCT_LSB +: 32]);
					cmp_field("payload_size", want.payload_size,
						m_tdata[ptsp_pkg::TD_SIZE_LSB +: 32]);
					cmp_field("element_index", want.element_index,
						m_tdata[ptsp_pkg::TD_ELEM_LSB +: 32]);
					cmp_field("info_position", want.info_position,
						m_tdata[ptsp_pkg::TD_IPOS_LSB +: 32]);
					cmp_field("clear_target", 32'(want.clear_target),
						32'(m_tuser[ptsp_pkg::TU_CLEAR_BIT]));
					cmp_field("bad_name", 32'(want.bad_name),
						32'(m_tuser[ptsp_pkg::TU_BAD_BIT]));
					cmp_field("list_end", 32'(want.list_end), 32'(m_tlast));
				end
			end
			if (s_fire) begin
				made = parse_byte(s_tdata, s_tuser, nxt);
				if (cur_byte.typed)
					hdr_q.push_back(cur_byte.want);
				else if (made)
					hdr_q.push_back(nxt);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle);
	end

	// present queued bytes, holding each until its transfer
	task automatic send_steps();
		int i;
		i = 0;
		while (i < byte_q.size()) begin
			@(negedge clk);
			if (s_tvalid && s_fire)
				i++;
			if (!s_tvalid || s_fire) begin
				if (i < byte_q.size() && $urandom_range(99) >= tx_idle) begin
					s_tvalid <= 1'b1;
					s_tdata  <= byte_q[i].data;
					s_tuser  <= byte_q[i].sobj;
					cur_byte <= byte_q[i];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
		byte_q.delete();
	endtask

	// wait for every expected record, then let the pipeline empty
	task automatic drain();
		while (hdr_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic cfg_write(input ptsp_pkg::cfg_idx_t idx, input logic [30:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			ptsp_pkg::CFG_NONE_NAME:   sh_none   = val;
			ptsp_pkg::CFG_TARGET_NAME: sh_target = val;
			default:                   sh_count  = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b, input bit sobj);
		step_t st;
		st        = '{idx: ptsp_pkg::CFG_NONE_NAME, default: '0};
		st.data   = b;
		st.sobj   = sobj;
		byte_q.push_back(st);
	endtask

	// compact index encoder, with padding, negative zero and junk in the fifth byte
	task automatic add_index(input logic [31:0] v, input bit sobj);
		logic [31:0] mag;
		logic [31:0] rem;
		logic [7:0]  b;
		bit          neg;
		int          len;
		neg = v[31];
		mag = neg ? (32'd0 - v) : v;
		len = 1;
		rem = mag >> 6;
		while (rem != 32'd0) begin
			len++;
			rem = rem >> 7;
		end
		if (len < 5 && $urandom_range(9) == 0)
			len++;
		if (mag == 32'd0 && $urandom_range(3) == 0)
			neg = 1'b1;
		add_byte({neg, len > 1, mag[5:0]}, sobj);
		for (int k = 1; k < len; k++) begin
			b[6:0] = 7'(mag >> (6 + 7 * (k - 1)));
			b[7]   = (k < len - 1);
			if (k == 4) begin
				b[7]   = 1'($urandom_range(1));
				b[6:5] = 2'($urandom_range(3));
			end
			add_byte(b, 1'b0);
		end
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0:       return 32'd0;
			1:       return 32'h7fffffff;
			2:       return 32'h80000000;
			3:       return 32'hffffffff;
			4, 5:    return $urandom_range(100);
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	// a name inside the table when it is not empty, the target now and then
	function automatic logic [31:0] pick_name();
		int p;
		if (sh_count == 31'd0)
			return $urandom_range(5);
		p = $urandom_range(99);
		if (p < 15 && sh_target < sh_count)
			return {1'b0, sh_target};
		if (p < 30)
			return $urandom % {1'b0, sh_count};
		return $urandom_range((sh_count > 31'd40) ? 40 : int'(sh_count) - 1);
	endfunction

	// one object: well-formed tags with random content, sometimes broken or pure noise
	task automatic gen_object();
		int          first, ntag, p, n, cut;
		logic [3:0]  ty;
		logic [2:0]  cls;
		bit          arr, big;
		logic [31:0] sz;
		first = byte_q.size();
		if ($urandom_range(99) < 5) begin
			repeat ($urandom_range(1, 12))
				add_byte(8'($urandom), $urandom_range(9) == 0);
			return;
		end
		ntag = $urandom_range(1, 6);
		for (int t = 0; t < ntag; t++) begin
			add_index(pick_name(), byte_q.size() == first);
			p   = $urandom_range(99);
			ty  = (p < 20) ? ptsp_pkg::TYPE_STRUCT : (p < 35) ? ptsp_pkg::TYPE_BOOL
				: 4'($urandom);
			cls = 3'($urandom);
			arr = 1'($urandom);
			add_byte({arr, cls, ty}, 1'b0);
			if (ty == ptsp_pkg::TYPE_STRUCT)
				add_index(rand_word(), 1'b0);
			big = 1'b0;
			if (cls > ptsp_pkg::LAST_FIXED_CLASS) begin
				n = (cls == 3'd5) ? 1 : (cls == 3'd6) ? 2 : 4;
				p = $urandom_range(99);
				if (p < 6) begin
					big = 1'b1;
					sz  = $urandom;
					if (n < 4)
						sz = sz & ((32'd1 << (8 * n)) - 32'd1);
				end else if (p < 25) begin
					sz = 32'd0;
				end else begin
					sz = $urandom_range(1, 6);
				end
				for (int k = 0; k < n; k++)
					add_byte(8'(sz >> (8 * k)), 1'b0);
			end else begin
				case (cls)
					3'd0:    sz = 32'd1;
					3'd1:    sz = 32'd2;
					3'd2:    sz = 32'd4;
					3'd3:    sz = 32'd12;
					default: sz = 32'd16;
				endcase
			end
			if (arr && ty != ptsp_pkg::TYPE_BOOL)
				add_index(rand_word(), 1'b0);
			// a long payload is cut short by the next object
			if (big) begin
				repeat ($urandom_range(3))
					add_byte(8'($urandom), 1'b0);
				return;
			end
			repeat (sz)
				add_byte(8'($urandom), 1'b0);
		end
		p = $urandom_range(99);
		if (p < 50)
			add_index({1'b0, sh_none}, 1'b0);
		else if (p < 70)
			add_index(($urandom_range(1) == 0) ? 32'd0 - $urandom_range(1, 5000)
				: {1'b0, sh_count} + $urandom_range(3), 1'b0);
		// truncated object
		if ($urandom_range(99) < 8 && byte_q.size() > first + 1) begin
			cut = $urandom_range(first + 1, byte_q.size() - 1);
			while (byte_q.size() > cut)
				void'(byte_q.pop_back());
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		errors    = 0;
		cycles    = 0;
		s_fire    = 1'b0;
		sh_none   = '0;
		sh_target = '0;
		sh_count  = '0;
		bpos      = '0;
		parser_clear();
		cur_byte  = '{idx: ptsp_pkg::CFG_NONE_NAME, default: '0};

		seg_count  = '{31'd64, 31'h7fffffff, 31'd1000, 31'h7fffffff, 31'd20, 31'd300000};
		seg_none   = '{31'd0, 31'h7ffffffe, 31'd999, 31'd12345, 31'd7, 31'h155};
		seg_target = '{31'd5, 31'h7ffffffd, 31'd0, 31'h7fffffff, 31'd19, 31'h2aa};

		// directed table: data, start, write, register, value, typed, expected record
		dir_rows = '{
			// bytes before any start, empty name table
			'{8'h05, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b1,
				stop_rec(32'd5, 1'b0, 1'b1)},
			// negative zero name
			'{8'h80, 1'b1, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b1,
				stop_rec(32'd0, 1'b0, 1'b1)},
			// ignored after the error
			'{8'ha5, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, ptsp_pkg::CFG_NAME_COUNT, 31'd100, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, ptsp_pkg::CFG_TARGET_NAME, 31'd7, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, ptsp_pkg::CFG_NONE_NAME, 31'd99, 1'b0, '0},
			// target name with array bit and a two byte element index
			'{8'h07, 1'b1, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'h82, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'h41, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			// struct with a five byte name, then a one byte size of zero
			'{8'h0a, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'h5a, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			// terminator straight after a zero payload
			'{8'h63, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b1,
				stop_rec(32'd99, 1'b1, 1'b0)},
			'{8'h7e, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			// negative name in a new object
			'{8'he4, 1'b1, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, ptsp_pkg::CFG_NONE_NAME, 31'd0, 1'b1,
				stop_rec(32'hffffffdc, 1'b0, 1'b1)}
		};

		// reset held over rising edges, released at a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle = 23;
		rx_idle = 60;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				send_steps();
				drain();
				cfg_write(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				byte_q.push_back(dir_rows[i]);
			end
		end
		send_steps();

		// random segments, two per idling mode, a fresh register setting each
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			tx_idle = (seg < 2) ? 23 : (seg < 4) ? 60 : 0;
			rx_idle = (seg < 2) ? 60 : (seg < 4) ? 23 : 0;
			drain();
			cfg_write(ptsp_pkg::CFG_NAME_COUNT, seg_count[seg]);
			cfg_write(ptsp_pkg::CFG_NONE_NAME, seg_none[seg]);
			cfg_write(ptsp_pkg::CFG_TARGET_NAME, seg_target[seg]);
			while (byte_q.size() < SEG_BYTES)
				gen_object();
			send_steps();
		end

		drain();
		if (errors == 0 && hdr_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
